FILE: rtl/blsel_pkg.sv
// Package for the backlight level selector: sizes, command and status codes,
// controller state type and the result bundle. No dependencies.
package blsel_pkg;

  localparam int unsigned TableDepth = 32;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned LvlW       = 8;
  localparam int unsigned IdxOutW    = 5;
  localparam int unsigned CntOutW    = 6;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_INSERT  = 2'd1,
    CMD_REPORT  = 2'd2,
    CMD_REQUEST = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CHK,
    S_REQ_RD,
    S_REQ_CHK,
    S_FET_RD,
    S_FET_DATA,
    S_OUT
  } state_e;

  typedef struct packed {
    status_e              status;
    logic [IdxOutW-1:0]   chosen_index;
    logic [LvlW-1:0]      current_level;
    logic [LvlW-1:0]      max_level;
    logic [CntOutW-1:0]   entry_count;
  } result_t;

endpackage

FILE: rtl/blsel_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module blsel_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/blsel_ctrl.sv
// Sequencer for the level table: insertion-sort shifts, nearest-entry scan,
// clamping and the summary registers. Depends on blsel_pkg.
module blsel_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    command_i,
  input  logic [blsel_pkg::LvlW-1:0]    level_value_i,
  output logic                          ram_we_o,
  output logic [blsel_pkg::AddrW-1:0]   ram_waddr_o,
  output logic [blsel_pkg::LvlW-1:0]    ram_wdata_o,
  output logic [blsel_pkg::AddrW-1:0]   ram_raddr_o,
  input  logic [blsel_pkg::LvlW-1:0]    ram_rdata_i,
  input  logic                          out_busy_i,
  output logic                          res_load_o,
  output blsel_pkg::result_t            res_o
);

  blsel_pkg::state_e                state_q, state_d;
  blsel_pkg::status_e               status_q, status_d;
  logic [blsel_pkg::LvlW-1:0]       lv_q, lv_d;
  logic [blsel_pkg::LvlW-1:0]       prev_q, prev_d;
  logic [blsel_pkg::LvlW-1:0]       cur_q, cur_d;
  logic [blsel_pkg::LvlW-1:0]       first_q, first_d;
  logic [blsel_pkg::LvlW-1:0]       last_q, last_d;
  logic [blsel_pkg::CntW-1:0]       ptr_q, ptr_d;
  logic [blsel_pkg::CntW-1:0]       count_q, count_d;
  logic [blsel_pkg::AddrW-1:0]      idx_q, idx_d;

  blsel_pkg::cmd_e                  cmd;
  logic                             accept;
  logic                             is_full;
  logic                             is_empty;
  logic [blsel_pkg::CntW-1:0]       ptr_nx;
  logic [blsel_pkg::LvlW-1:0]       diff;
  logic [blsel_pkg::LvlW-1:0]       mid;
  logic                             hit;
  logic [blsel_pkg::AddrW-1:0]      hit_idx;
  logic [blsel_pkg::LvlW-1:0]       hit_val;
  logic [blsel_pkg::AddrW-1:0]      adj_idx;

  assign cmd      = blsel_pkg::cmd_e'(command_i);
  assign accept   = in_valid_i && (state_q == blsel_pkg::S_IDLE);
  assign is_full  = (count_q == blsel_pkg::CntW'(blsel_pkg::TableDepth));
  assign is_empty = (count_q == '0);
  assign ptr_nx   = ptr_q + 1'b1;
  assign diff     = ram_rdata_i - prev_q;
  assign mid      = prev_q + {1'b0, diff[blsel_pkg::LvlW-1:1]};

  // scan decision on the entry just read
  always_comb begin
    hit     = 1'b0;
    hit_idx = ptr_q[blsel_pkg::AddrW-1:0];
    hit_val = ram_rdata_i;
    if (ptr_q == '0 && lv_q < ram_rdata_i) begin
      hit = 1'b1;
    end else if (ptr_q != '0 && lv_q <= ram_rdata_i) begin
      hit = 1'b1;
      if (lv_q <= mid) begin
        hit_idx = blsel_pkg::AddrW'(ptr_q - 1'b1);
        hit_val = prev_q;
      end
    end else if (ptr_nx == count_q) begin
      hit = 1'b1;
    end
    adj_idx = hit_idx;
    if (hit_val == cur_q) begin
      if (lv_q > cur_q && (blsel_pkg::CntW'(hit_idx) + 1'b1) < count_q) begin
        adj_idx = hit_idx + 1'b1;
      end else if (lv_q < cur_q && hit_idx != '0) begin
        adj_idx = hit_idx - 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      blsel_pkg::S_IDLE: begin
        if (accept) begin
          case (cmd)
            blsel_pkg::CMD_INSERT:  state_d = is_full ? blsel_pkg::S_OUT
                                                      : blsel_pkg::S_INS_RD;
            blsel_pkg::CMD_REQUEST: state_d = is_empty ? blsel_pkg::S_OUT
                                                       : blsel_pkg::S_REQ_RD;
            default:                state_d = blsel_pkg::S_OUT;
          endcase
        end
      end
      blsel_pkg::S_INS_RD: begin
        state_d = (ptr_q == '0) ? blsel_pkg::S_OUT : blsel_pkg::S_INS_CHK;
      end
      blsel_pkg::S_INS_CHK: begin
        state_d = (ram_rdata_i > lv_q) ? blsel_pkg::S_INS_RD : blsel_pkg::S_OUT;
      end
      blsel_pkg::S_REQ_RD:   state_d = blsel_pkg::S_REQ_CHK;
      blsel_pkg::S_REQ_CHK: begin
        state_d = hit ? blsel_pkg::S_FET_RD : blsel_pkg::S_REQ_RD;
      end
      blsel_pkg::S_FET_RD:   state_d = blsel_pkg::S_FET_DATA;
      blsel_pkg::S_FET_DATA: state_d = blsel_pkg::S_OUT;
      blsel_pkg::S_OUT: begin
        if (!out_busy_i) begin
          state_d = blsel_pkg::S_IDLE;
        end
      end
      default: state_d = blsel_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    status_d    = status_q;
    lv_d        = lv_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    first_d     = first_q;
    last_d      = last_q;
    ptr_d       = ptr_q;
    count_d     = count_q;
    idx_d       = idx_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = ptr_q[blsel_pkg::AddrW-1:0];
    ram_wdata_o = lv_q;
    ram_raddr_o = ptr_q[blsel_pkg::AddrW-1:0];
    res_load_o  = 1'b0;
    case (state_q)
      blsel_pkg::S_IDLE: begin
        if (accept) begin
          status_d = blsel_pkg::ST_OK;
          lv_d     = level_value_i;
          ptr_d    = '0;
          case (cmd)
            blsel_pkg::CMD_CLEAR: count_d = '0;
            blsel_pkg::CMD_INSERT: begin
              if (is_full) begin
                status_d = blsel_pkg::ST_FULL;
              end else begin
                ptr_d   = count_q;
                count_d = count_q + 1'b1;
                if (is_empty) begin
                  first_d = level_value_i;
                  last_d  = level_value_i;
                end else begin
                  if (level_value_i < first_q) first_d = level_value_i;
                  if (level_value_i > last_q)  last_d  = level_value_i;
                end
              end
            end
            blsel_pkg::CMD_REPORT: begin
              if (is_empty) begin
                status_d = blsel_pkg::ST_EMPTY;
              end else if (level_value_i < first_q) begin
                cur_d = first_q;
              end else if (level_value_i > last_q) begin
                cur_d = last_q;
              end else begin
                cur_d = level_value_i;
              end
            end
            default: begin
              if (is_empty) status_d = blsel_pkg::ST_EMPTY;
            end
          endcase
        end
      end
      blsel_pkg::S_INS_RD: begin
        if (ptr_q == '0) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = '0;
          ram_wdata_o = lv_q;
        end else begin
          ram_raddr_o = blsel_pkg::AddrW'(ptr_q - 1'b1);
        end
      end
      blsel_pkg::S_INS_CHK: begin
        ram_we_o = 1'b1;
        if (ram_rdata_i > lv_q) begin
          ram_wdata_o = ram_rdata_i;
          ptr_d       = ptr_q - 1'b1;
        end
      end
      blsel_pkg::S_REQ_CHK: begin
        if (hit) begin
          idx_d = adj_idx;
        end else begin
          prev_d = ram_rdata_i;
          ptr_d  = ptr_nx;
        end
      end
      blsel_pkg::S_FET_RD:   ram_raddr_o = idx_q;
      blsel_pkg::S_FET_DATA: cur_d = ram_rdata_i;
      blsel_pkg::S_OUT:      res_load_o = !out_busy_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= blsel_pkg::S_IDLE;
      status_q <= blsel_pkg::ST_OK;
      cur_q    <= '0;
      count_q  <= '0;
      idx_q    <= '0;
      ptr_q    <= '0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      cur_q    <= cur_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      ptr_q    <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lv_q    <= lv_d;
    prev_q  <= prev_d;
    first_q <= first_d;
    last_q  <= last_d;
  end

  assign in_stall_o          = (state_q != blsel_pkg::S_IDLE);
  assign res_o.status        = status_q;
  assign res_o.chosen_index  = blsel_pkg::IdxOutW'(idx_q);
  assign res_o.current_level = cur_q;
  assign res_o.max_level     = is_empty ? '0 : last_q;
  assign res_o.entry_count   = blsel_pkg::CntOutW'(count_q);

endmodule

FILE: rtl/blsel_out.sv
// Output register for result beats, holds a beat while the sink stalls.
// Depends on blsel_pkg.
module blsel_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  blsel_pkg::result_t            res_i,
  output logic                          busy_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output blsel_pkg::result_t            res_o
);

  logic               valid_q, valid_d;
  blsel_pkg::result_t res_q;

  assign busy_o = valid_q && out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/backlight_level_selector_top.sv
// Backlight level selector: one beat in, one result beat out, table in RAM.
// Clear, report, full insert and empty request go straight to the output state.
// An insert shifts larger entries up one by one; a request scans from index 0.
// One item at a time: input stalls until the result is loaded; the RAM has one port each.
// Reset clears control, count, current level and index; table RAM is not cleared.
// Depends on blsel_pkg, blsel_ram, blsel_ctrl, blsel_out.
module backlight_level_selector_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  level_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [4:0]  chosen_index_o,
  output logic [7:0]  current_level_o,
  output logic [7:0]  max_level_o,
  output logic [5:0]  entry_count_o
);

  logic                          ram_we;
  logic [blsel_pkg::AddrW-1:0]   ram_waddr;
  logic [blsel_pkg::LvlW-1:0]    ram_wdata;
  logic [blsel_pkg::AddrW-1:0]   ram_raddr;
  logic [blsel_pkg::LvlW-1:0]    ram_rdata;
  logic                          out_busy;
  logic                          res_load;
  blsel_pkg::result_t            res_next;
  blsel_pkg::result_t            res_out;

  blsel_ram #(
    .Width (blsel_pkg::LvlW),
    .Depth (blsel_pkg::TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  blsel_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .level_value_i (level_value_i),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .out_busy_i    (out_busy),
    .res_load_o    (res_load),
    .res_o         (res_next)
  );

  blsel_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_load),
    .res_i       (res_next),
    .busy_o      (out_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign status_o        = res_out.status;
  assign chosen_index_o  = res_out.chosen_index;
  assign current_level_o = res_out.current_level;
  assign max_level_o     = res_out.max_level;
  assign entry_count_o   = res_out.entry_count;

endmodule
